@@ src/stat_pkg.sv @@
`default_nettype none
package stat_pkg;

  localparam int MAX_SECTIONS = 16;
  localparam int SEC_AW = $clog2(MAX_SECTIONS);
  localparam int SEC_CW = $clog2(MAX_SECTIONS + 1);
  localparam int ALIGN_W = 17;

  localparam logic [2:0] CMD_CLEAR     = 3'd0;
  localparam logic [2:0] CMD_LOAD      = 3'd1;
  localparam logic [2:0] CMD_ADD       = 3'd2;
  localparam logic [2:0] CMD_VA2OFF    = 3'd3;
  localparam logic [2:0] CMD_OFF2VA    = 3'd4;
  localparam logic [2:0] CMD_OFF2INDEX = 3'd5;
  localparam logic [2:0] CMD_ALIGN     = 3'd6;

  localparam logic [1:0] REG_FILE_ALIGN    = 2'd0;
  localparam logic [1:0] REG_SECTION_ALIGN = 2'd1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] query_address;
    logic [31:0] entry_virtual_address;
    logic [31:0] entry_virtual_size;
    logic [31:0] entry_raw_pointer;
    logic [31:0] entry_raw_size;
    logic [31:0] new_section_size;
  } request_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [3:0]  section_index;
    logic        found;
    logic        error;
  } result_t;

  typedef struct packed {
    logic [31:0] va;
    logic [31:0] vs;
    logic [31:0] rp;
    logic [31:0] rs;
  } entry_t;

endpackage
`default_nettype wire

@@ src/section_table_address_translator_unit.sv @@
`default_nettype none
// Section table translator. A command is taken when start is high and busy is low;
// its single result shows on result for one cycle with done high and cannot be
// stalled. The table sits in one 16-entry memory whose entries are read one at a
// time, each through a wait state and a read state; lookups scan from entry 0 and
// clear or load finish without a scan. Rounding uses a shared radix-2 remainder
// unit serially. Add section and align all round four values per entry.
module section_table_address_translator_unit import stat_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire request_t                request,
  output logic                         busy,
  output logic                         done,
  output result_t                      result,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [ALIGN_W-1:0]      cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WAIT  = 6'b000010,
    S_READ  = 6'b000100,
    S_LOAD  = 6'b001000,
    S_DIV   = 6'b010000,
    S_WRITE = 6'b100000
  } state_t;

  state_t              state;
  logic                fin;
  logic [SEC_AW-1:0]   idx;
  logic [SEC_CW-1:0]   count;
  logic [1:0]          k;
  entry_t              cur;
  entry_t              rd_data;
  entry_t              mem [MAX_SECTIONS];
  request_t            req;
  result_t             res;
  logic [31:0]         dv;
  logic [31:0]         tval;
  logic [ALIGN_W-1:0]  rem;
  logic [ALIGN_W-1:0]  gran;
  logic [4:0]          bitcnt;
  logic [ALIGN_W-1:0]  file_align;
  logic [ALIGN_W-1:0]  sect_align;

  logic                acc;
  logic                full;
  logic                last;
  logic                is_add;
  logic                mem_we;
  logic [SEC_AW-1:0]   waddr;
  entry_t              wdata;
  logic [31:0]         base;
  logic [31:0]         top;
  logic                hit;
  logic [31:0]         xlat;
  logic [31:0]         opnd;
  logic [ALIGN_W-1:0]  al;
  logic [ALIGN_W-1:0]  al_g;
  logic [ALIGN_W:0]    shifted;
  logic [ALIGN_W-1:0]  rem_next;
  logic [31:0]         rnd;

  assign busy      = (state != S_IDLE) || fin;
  assign done      = fin;
  assign result    = res;
  assign cfg_ready = 1'b1;

  assign acc    = start && !busy;
  assign full   = count == SEC_CW'(MAX_SECTIONS);
  assign last   = (SEC_CW'(idx) + SEC_CW'(1)) == count;
  assign is_add = req.cmd == CMD_ADD;

  always_comb begin
    mem_we = 1'b0;
    waddr  = idx;
    wdata  = cur;
    if (acc && request.cmd == CMD_LOAD && !full) begin
      mem_we = 1'b1;
      waddr  = count[SEC_AW-1:0];
      wdata  = '{va: request.entry_virtual_address, vs: request.entry_virtual_size,
                 rp: request.entry_raw_pointer, rs: request.entry_raw_size};
    end else if (state == S_WRITE) begin
      mem_we = 1'b1;
      waddr  = is_add ? count[SEC_AW-1:0] : idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[idx];
  end

  always_comb begin
    base = (req.cmd == CMD_VA2OFF) ? rd_data.va : rd_data.rp;
    top  = base + rd_data.rs;
    hit  = (req.query_address >= base) && (req.query_address < top);
    if (req.cmd == CMD_VA2OFF) begin
      xlat = req.query_address + rd_data.rp - rd_data.va;
    end else if (req.cmd == CMD_OFF2VA) begin
      xlat = req.query_address + rd_data.va - rd_data.rp;
    end else begin
      xlat = '0;
    end
  end

  always_comb begin
    case (k)
      2'd0: begin
        opnd = is_add ? cur.rp + cur.rs : cur.rp;
        al   = file_align;
      end
      2'd1: begin
        opnd = is_add ? cur.va + cur.vs : cur.va;
        al   = sect_align;
      end
      2'd2: begin
        opnd = is_add ? req.new_section_size : cur.rs;
        al   = file_align;
      end
      default: begin
        opnd = is_add ? cur.rs : cur.vs;
        al   = sect_align;
      end
    endcase
    al_g = (al == '0) ? ALIGN_W'(1) : al;
  end

  always_comb begin
    shifted = {rem, dv[31]};
    if (shifted >= {1'b0, gran}) begin
      rem_next = ALIGN_W'(shifted - {1'b0, gran});
    end else begin
      rem_next = shifted[ALIGN_W-1:0];
    end
    rnd = tval - {{(32-ALIGN_W){1'b0}}, rem_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_align <= ALIGN_W'(512);
      sect_align <= ALIGN_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FILE_ALIGN) begin
        file_align <= cfg_data;
      end else if (cfg_index == REG_SECTION_ALIGN) begin
        sect_align <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin   <= 1'b0;
      count <= '0;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            req <= request;
            case (request.cmd)
              CMD_CLEAR: begin
                res   <= '0;
                count <= '0;
                fin   <= 1'b1;
              end
              CMD_LOAD: begin
                if (!full) begin
                  count <= count + SEC_CW'(1);
                  res   <= '{result_value: '0, section_index: 4'(count),
                             found: 1'b0, error: 1'b0};
                end else begin
                  res <= '{result_value: '0, section_index: '0, found: 1'b0, error: 1'b1};
                end
                fin <= 1'b1;
              end
              CMD_ADD: begin
                if (count == '0 || full) begin
                  res <= '{result_value: '0, section_index: '0, found: 1'b0, error: 1'b1};
                  fin <= 1'b1;
                end else begin
                  res   <= '0;
                  idx   <= SEC_AW'(count - SEC_CW'(1));
                  state <= S_WAIT;
                end
              end
              CMD_VA2OFF, CMD_OFF2VA, CMD_OFF2INDEX, CMD_ALIGN: begin
                res <= '0;
                if (count == '0) begin
                  fin <= 1'b1;
                end else begin
                  idx   <= '0;
                  state <= S_WAIT;
                end
              end
              default: begin
                res <= '0;
                fin <= 1'b1;
              end
            endcase
          end else begin
            fin <= 1'b0;
          end
        end
        S_WAIT: begin
          state <= S_READ;
        end
        S_READ: begin
          if (req.cmd == CMD_ADD || req.cmd == CMD_ALIGN) begin
            cur   <= rd_data;
            k     <= 2'd0;
            state <= S_LOAD;
          end else if (hit) begin
            res   <= '{result_value: xlat, section_index: 4'(idx), found: 1'b1, error: 1'b0};
            fin   <= 1'b1;
            state <= S_IDLE;
          end else if (last) begin
            fin   <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= idx + SEC_AW'(1);
            state <= S_WAIT;
          end
        end
        S_LOAD: begin
          gran   <= al_g;
          tval   <= opnd + {{(32-ALIGN_W){1'b0}}, al_g} - 32'd1;
          dv     <= opnd + {{(32-ALIGN_W){1'b0}}, al_g} - 32'd1;
          rem    <= '0;
          bitcnt <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          rem    <= rem_next;
          dv     <= {dv[30:0], 1'b0};
          bitcnt <= bitcnt + 5'd1;
          if (bitcnt == 5'd31) begin
            case (k)
              2'd0:    cur.rp <= rnd;
              2'd1:    cur.va <= rnd;
              2'd2:    cur.rs <= rnd;
              default: cur.vs <= rnd;
            endcase
            if (k == 2'd3) begin
              state <= S_WRITE;
            end else begin
              k     <= k + 2'd1;
              state <= S_LOAD;
            end
          end
        end
        S_WRITE: begin
          if (is_add) begin
            res   <= '{result_value: cur.va, section_index: 4'(count),
                       found: 1'b0, error: 1'b0};
            count <= count + SEC_CW'(1);
            fin   <= 1'b1;
            state <= S_IDLE;
          end else if (last) begin
            res   <= '{result_value: cur.va + cur.vs, section_index: '0,
                       found: 1'b0, error: 1'b0};
            fin   <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= idx + SEC_AW'(1);
            state <= S_WAIT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted without going busy");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.found && result.error))
    else $error("found and error both set");
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= SEC_CW'(MAX_SECTIONS))
    else $error("section count overflow");

endmodule
`default_nettype wire
